FILE: hdl/trs_pkg.sv
// Types, codes and constants shared by the timed relay sequencer modules.
package trs_pkg;

    localparam int RELAY_LINES = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_ADDR_W  = 3;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_STARTING = 2'd1,
        PH_RUNNING  = 2'd2,
        PH_FINISHED = 2'd3
    } phase_t;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_STEP_SECONDS   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_RELAY_ENABLE   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WEEKDAY_ENABLE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_HOUR   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_MINUTE = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIGGER_SECOND = 3'd5;

    localparam logic [9:0]  MILLIS_PER_SECOND = 10'd1000;
    // floor(x / 1000) == (x * DIV1000_MAGIC) >> DIV1000_SHIFT for every 32-bit x.
    localparam logic [31:0] DIV1000_MAGIC = 32'h10624DD3;
    localparam int          DIV1000_SHIFT = 38;

    typedef struct packed {
        logic [15:0] step_seconds;
        logic [7:0]  relay_enable_bits;
        logic [6:0]  weekday_enable_bits;
        logic [4:0]  trigger_hour;
        logic [5:0]  trigger_minute;
        logic [5:0]  trigger_second;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_millis;
        logic [2:0]  weekday;
        logic [4:0]  clock_hour;
        logic [5:0]  clock_minute;
        logic [5:0]  clock_second;
    } item_t;

    typedef struct packed {
        logic [7:0]  relay_lines;
        logic [1:0]  phase_code;
        logic [3:0]  current_relay;
        logic        is_running;
        logic [22:0] elapsed_seconds;
        logic [15:0] remaining_seconds;
        logic [18:0] program_seconds;
    } result_t;

    // Status after one word has been applied, before the seconds are derived.
    typedef struct packed {
        logic [7:0]  relay_lines;
        logic [1:0]  phase_code;
        logic [3:0]  current_relay;
        logic        is_running;
        logic [31:0] elapsed_millis;
    } stat_t;

endpackage

FILE: hdl/timed_relay_sequencer_top.sv
// Top level of the timed relay sequencer: configuration registers and the two pipeline parts.
//
// The sequencer takes one command word per clock cycle, unless item_stall holds it back, and
// returns one status word for each, in order. A word passes four registers: the input
// register, the state update, the millisecond-to-second multiply and the output register.
// The state update finishes a whole tick, start or stop at once, so it adds no wait
// between words. Stalls on the output fill bubbles first, so the input is held back only
// when every stage is full. There is no clearing pass after reset. Configuration writes
// take effect at once and must be made while no word is in flight.
module timed_relay_sequencer_top #(
    parameter int RELAY_COUNT = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [trs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [trs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               item_valid,
    output logic                               item_stall,
    input  trs_pkg::item_t                     item,
    output logic                               result_valid,
    input  logic                               result_stall,
    output trs_pkg::result_t                   result
);
    import trs_pkg::*;

    cfg_t  cfg_reg;
    logic  stat_valid;
    logic  stat_stall;
    stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                REG_STEP_SECONDS:   cfg_reg.step_seconds        <= cfg_data;
                REG_RELAY_ENABLE:   cfg_reg.relay_enable_bits   <= cfg_data[7:0];
                REG_WEEKDAY_ENABLE: cfg_reg.weekday_enable_bits <= cfg_data[6:0];
                REG_TRIGGER_HOUR:   cfg_reg.trigger_hour        <= cfg_data[4:0];
                REG_TRIGGER_MINUTE: cfg_reg.trigger_minute      <= cfg_data[5:0];
                REG_TRIGGER_SECOND: cfg_reg.trigger_second      <= cfg_data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    trs_ctrl #(
        .RELAY_COUNT (RELAY_COUNT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .stat_valid (stat_valid),
        .stat_stall (stat_stall),
        .stat       (stat)
    );

    trs_stat #(
        .RELAY_COUNT (RELAY_COUNT)
    ) u_stat (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .stat_valid   (stat_valid),
        .stat_stall   (stat_stall),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

FILE: hdl/trs_ctrl.sv
// Input register, sequencer state and the single-pass state update.
module trs_ctrl #(
    parameter int RELAY_COUNT = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  trs_pkg::cfg_t   cfg,
    input  logic            item_valid,
    output logic            item_stall,
    input  trs_pkg::item_t  item,
    output logic            stat_valid,
    input  logic            stat_stall,
    output trs_pkg::stat_t  stat
);
    import trs_pkg::*;

    item_t                  item_reg;
    logic                   item_valid_reg;
    phase_t                 phase_reg, phase_next;
    logic [3:0]             relay_index_reg, relay_index_next;
    logic [31:0]            stamp_reg, stamp_next;
    logic [RELAY_LINES-1:0] drive_reg, drive_next;
    stat_t                  stat_reg, stat_next;
    logic                   stat_valid_reg;

    logic                   advance;
    logic                   load_in;
    logic [7:0]             weekday_bits;
    logic                   trigger_hit;
    phase_t                 phase_eff;
    logic [4:0]             search_from;
    logic                   hit;
    logic [2:0]             hit_idx;
    logic [31:0]            since_stamp;
    logic [25:0]            step_millis;
    logic                   step_due;
    logic [RELAY_LINES-1:0] drive_off;

    assign advance    = item_valid_reg && (!stat_valid_reg || !stat_stall);
    assign item_stall = item_valid_reg && stat_valid_reg && stat_stall;
    assign load_in    = item_valid && !item_stall;

    // Weekday seven has no enable bit and never matches.
    assign weekday_bits = {1'b0, cfg.weekday_enable_bits};
    assign trigger_hit  = weekday_bits[item_reg.weekday]
                          && item_reg.clock_hour == cfg.trigger_hour
                          && item_reg.clock_minute == cfg.trigger_minute
                          && item_reg.clock_second == cfg.trigger_second;

    assign since_stamp = item_reg.now_millis - stamp_reg;
    assign step_millis = 26'(cfg.step_seconds) * 26'(MILLIS_PER_SECOND);
    assign step_due    = since_stamp >= {6'b0, step_millis};

    always_comb
    begin
        phase_eff = phase_reg;
        if (item_reg.opcode == OP_TICK && phase_reg == PH_IDLE && trigger_hit)
        begin
            phase_eff = PH_STARTING;
        end
    end

    // Lowest enabled relay at or after search_from; relays past the eighth never take part.
    assign search_from = (phase_eff == PH_STARTING) ? 5'd0 : {1'b0, relay_index_reg} + 5'd1;

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = RELAY_LINES - 1; i >= 0; i--)
        begin
            if (i < RELAY_COUNT && 5'(i) >= search_from && cfg.relay_enable_bits[i])
            begin
                hit     = 1'b1;
                hit_idx = 3'(i);
            end
        end
    end

    always_comb
    begin
        drive_off = drive_reg;
        if (!relay_index_reg[3])
        begin
            drive_off[relay_index_reg[2:0]] = 1'b0;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        relay_index_next = relay_index_reg;
        stamp_next       = stamp_reg;
        drive_next       = drive_reg;
        case (item_reg.opcode)
            OP_TICK:
            begin
                unique case (phase_eff)
                    PH_IDLE:
                    begin
                    end
                    PH_FINISHED:
                    begin
                        phase_next       = PH_IDLE;
                        relay_index_next = '0;
                        stamp_next       = '0;
                        drive_next       = '0;
                    end
                    PH_STARTING:
                    begin
                        if (cfg.step_seconds == '0)
                        begin
                            phase_next       = PH_FINISHED;
                            relay_index_next = '0;
                            stamp_next       = '0;
                        end
                        else if (hit)
                        begin
                            phase_next       = PH_RUNNING;
                            relay_index_next = {1'b0, hit_idx};
                            stamp_next       = item_reg.now_millis;
                            drive_next       = '0;
                            drive_next[hit_idx] = 1'b1;
                        end
                        else
                        begin
                            // No relay enabled: the index is left just past the last one.
                            phase_next       = PH_FINISHED;
                            relay_index_next = 4'(RELAY_COUNT);
                            stamp_next       = '0;
                            drive_next       = '0;
                        end
                    end
                    PH_RUNNING:
                    begin
                        if (step_due)
                        begin
                            if (hit)
                            begin
                                relay_index_next    = {1'b0, hit_idx};
                                stamp_next          = item_reg.now_millis;
                                drive_next          = drive_off;
                                drive_next[hit_idx] = 1'b1;
                            end
                            else
                            begin
                                phase_next       = PH_FINISHED;
                                relay_index_next = '0;
                                stamp_next       = '0;
                                drive_next       = drive_off;
                            end
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_START:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_next = PH_STARTING;
                end
            end
            OP_STOP:
            begin
                phase_next = PH_FINISHED;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        stat_next.relay_lines   = drive_next;
        stat_next.phase_code    = phase_next;
        stat_next.current_relay = relay_index_next;
        stat_next.is_running    = phase_next == PH_RUNNING;
        // A zero stamp reads as no stamp, so elapsed time is reported as zero.
        if (phase_next == PH_RUNNING && stamp_next != '0)
        begin
            stat_next.elapsed_millis = item_reg.now_millis - stamp_next;
        end
        else
        begin
            stat_next.elapsed_millis = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg  <= 1'b0;
            stat_valid_reg  <= 1'b0;
            phase_reg       <= PH_IDLE;
            relay_index_reg <= '0;
            stamp_reg       <= '0;
            drive_reg       <= '0;
        end
        else
        begin
            if (!item_stall)
            begin
                item_valid_reg <= item_valid;
            end
            if (!stat_valid_reg || !stat_stall)
            begin
                stat_valid_reg <= item_valid_reg;
            end
            if (advance)
            begin
                phase_reg       <= phase_next;
                relay_index_reg <= relay_index_next;
                stamp_reg       <= stamp_next;
                drive_reg       <= drive_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_in)
        begin
            item_reg <= item;
        end
        if (advance)
        begin
            stat_reg <= stat_next;
        end
    end

    assign stat_valid = stat_valid_reg;
    assign stat       = stat_reg;

endmodule

FILE: hdl/trs_stat.sv
// Converts elapsed milliseconds to seconds and forms the status word in two stages.
module trs_stat #(
    parameter int RELAY_COUNT = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  trs_pkg::cfg_t     cfg,
    input  logic              stat_valid,
    output logic              stat_stall,
    input  trs_pkg::stat_t    stat,
    output logic              result_valid,
    input  logic              result_stall,
    output trs_pkg::result_t  result
);
    import trs_pkg::*;

    result_t     mid_reg, mid_next;
    logic        mid_valid_reg;
    result_t     result_reg, result_next;
    logic        result_valid_reg;

    logic        mid_load;
    logic        result_load;
    logic [63:0] product;
    logic [3:0]  enabled_count;
    logic [19:0] program_full;

    assign result_load = mid_valid_reg && (!result_valid_reg || !result_stall);
    assign stat_stall  = mid_valid_reg && result_valid_reg && result_stall;
    assign mid_load    = stat_valid && !stat_stall;

    assign product = 64'(stat.elapsed_millis) * 64'(DIV1000_MAGIC);

    always_comb
    begin
        enabled_count = '0;
        for (int i = 0; i < RELAY_LINES; i++)
        begin
            if (i < RELAY_COUNT && cfg.relay_enable_bits[i])
            begin
                enabled_count = enabled_count + 4'd1;
            end
        end
    end

    assign program_full = 20'(enabled_count) * 20'(cfg.step_seconds);

    always_comb
    begin
        mid_next.relay_lines       = stat.relay_lines;
        mid_next.phase_code        = stat.phase_code;
        mid_next.current_relay     = stat.current_relay;
        mid_next.is_running        = stat.is_running;
        mid_next.elapsed_seconds   = product[DIV1000_SHIFT +: 23];
        mid_next.remaining_seconds = '0;
        mid_next.program_seconds   = program_full[18:0];
    end

    always_comb
    begin
        result_next = mid_reg;
        if (mid_reg.elapsed_seconds >= {7'b0, cfg.step_seconds})
        begin
            result_next.remaining_seconds = '0;
        end
        else
        begin
            result_next.remaining_seconds = cfg.step_seconds - mid_reg.elapsed_seconds[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (!stat_stall)
            begin
                mid_valid_reg <= stat_valid;
            end
            if (!result_valid_reg || !result_stall)
            begin
                result_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_load)
        begin
            mid_reg <= mid_next;
        end
        if (result_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
